FILE: sv/bncg_pkg.sv
package bncg_pkg;

	localparam int VARIABLES   = 16;
	localparam int TABLE_DEPTH = 1024;
	localparam int VAR_W       = $clog2(VARIABLES);
	localparam int TD_W        = $clog2(TABLE_DEPTH);
	localparam int MEM_DEPTH   = VARIABLES * TABLE_DEPTH;
	localparam int MEM_AW      = $clog2(MEM_DEPTH);

	localparam logic [1:0] KIND_ROW    = 2'd0;
	localparam logic [1:0] KIND_STRUCT = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_PARENT  = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  row_value;
		logic        row_end;
		logic [3:0]  target_variable;
		logic [15:0] parent_mask;
		logic [7:0]  value_count;
		logic [9:0]  query_config;
		logic [7:0]  query_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  variable;
		logic [2:0]  status;
		logic [9:0]  config_index;
		logic [7:0]  observed_value;
		logic [31:0] joint_count;
		logic [31:0] config_count;
		logic [31:0] variable_total;
		logic        last;
	} out_item_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] x);
		return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
	endfunction

endpackage

FILE: sv/bncg_ram.sv
module bncg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/bncg_walker.sv
// Forms the parent configuration of one variable by visiting the 16 parent slots,
// one per cycle, with a narrow multiply-accumulate saturated at the table depth.
module bncg_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] parents,
	input  logic [7:0]  own_value,
	input  logic        own_missing,
	input  logic [7:0]  own_vc,
	input  logic [7:0]  row_vals [bncg_pkg::VARIABLES],
	input  logic [bncg_pkg::VARIABLES-1:0] row_miss,
	input  logic [7:0]  vcs [bncg_pkg::VARIABLES],
	output logic        done,
	output logic [2:0]  status,
	output logic [bncg_pkg::TD_W-1:0] cfg,
	output logic [bncg_pkg::TD_W-1:0] jidx
);
	localparam int SW = bncg_pkg::TD_W + 1;
	logic              busy_q;
	logic [4:0]        p_q;
	logic [SW-1:0]     pci_q, base_q;
	logic [2:0]        st_q;
	logic [SW+7:0]     prod;
	logic [SW+8:0]     idx;
	logic [SW+8:0]     sum;
	logic [SW+7:0]     nb;
	logic [3:0]        pi;

	assign pi = p_q[3:0];
	assign sum = {9'd0, pci_q} + {1'b0, {8'd0, base_q} * {{SW{1'b0}}, row_vals[pi]}};
	assign nb = {8'd0, base_q} * {{SW{1'b0}}, vcs[pi]};
	assign prod = {8'd0, pci_q} * {{SW{1'b0}}, own_vc};
	assign idx = {1'b0, prod} + {{(SW+1){1'b0}}, own_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			st_q   <= bncg_pkg::ST_COUNTED;
			p_q    <= '0;
			pci_q  <= '0;
			base_q <= SW'(1);
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= !own_missing;
				done   <= own_missing;
				st_q   <= own_missing ? bncg_pkg::ST_MISSING : bncg_pkg::ST_COUNTED;
				p_q    <= '0;
				pci_q  <= '0;
				base_q <= SW'(1);
			end else if (busy_q) begin
				if (p_q == 5'd16) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					if (st_q == bncg_pkg::ST_COUNTED &&
						(own_value >= own_vc || pci_q >= SW'(bncg_pkg::TABLE_DEPTH) ||
						 idx >= (SW+9)'(bncg_pkg::TABLE_DEPTH)))
						st_q <= bncg_pkg::ST_RANGE;
				end else begin
					p_q <= p_q + 5'd1;
					if (st_q == bncg_pkg::ST_COUNTED && parents[pi]) begin
						if (row_miss[pi]) begin
							st_q <= bncg_pkg::ST_PARENT;
						end else if (row_vals[pi] >= vcs[pi]) begin
							st_q <= bncg_pkg::ST_RANGE;
						end else begin
							pci_q  <= (sum > (SW+9)'(bncg_pkg::TABLE_DEPTH)) ?
								SW'(bncg_pkg::TABLE_DEPTH) : sum[SW-1:0];
							base_q <= (nb > (SW+8)'(bncg_pkg::TABLE_DEPTH)) ?
								SW'(bncg_pkg::TABLE_DEPTH) : nb[SW-1:0];
						end
					end
				end
			end
		end
	end

	assign status = st_q;
	assign cfg = pci_q[bncg_pkg::TD_W-1:0];
	assign jidx = idx[bncg_pkg::TD_W-1:0];
endmodule

FILE: sv/bayes_net_count_gatherer.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | bncg_pkg::in_item_t
// out     | out | out_valid / out_ready| bncg_pkg::out_item_t
// cfg     | in  | cfg_we               | cfg_wdata (missing code)
// A row value without row end is stored and the block stays idle. A row end then walks
// each variable: the parent walk over 16 slots, a memory read and a write back.
// Structure requests are answered from idle, read requests after a memory read; a clear
// sweeps the count memories, and reset starts the same sweep before any request is taken.
// A result waits in the output register until taken; the block stalls meanwhile,
// and the walk of the next variable does not start before the previous result is taken.
module bayes_net_count_gatherer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bncg_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bncg_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	localparam int VN = bncg_pkg::VARIABLES;
	localparam int AW = bncg_pkg::MEM_AW;
	localparam int TW = bncg_pkg::TD_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLEAR = 9'b000000010,
		S_WALK  = 9'b000000100,
		S_WAIT  = 9'b000001000,
		S_RD    = 9'b000010000,
		S_WB    = 9'b000100000,
		S_OUT   = 9'b001000000,
		S_QRD   = 9'b010000000,
		S_QOUT  = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [7:0]        miss_q;
	logic [7:0]        row_q [VN];
	logic [4:0]        pos_q;
	logic [15:0]       par_q [VN];
	logic [7:0]        vc_q [VN];
	logic [31:0]       tot_q [VN];
	logic [AW-1:0]     clr_q;
	logic [3:0]        var_q;
	bncg_pkg::in_item_t req_q;
	bncg_pkg::out_item_t out_q;
	logic              start;
	logic              done;
	logic [2:0]        wst;
	logic [TW-1:0]     wcfg, wjidx;
	logic [TW-1:0]     cfg_q, jidx_q;
	logic [VN-1:0]     row_miss;
	logic              jwe;
	logic [AW-1:0]     jwa, cwa, jra, cra;
	logic [31:0]       jwd, cwd, jrd, crd;
	logic              q_ok;
	logic [17:0]       qidx;

	always_comb begin
		for (int i = 0; i < VN; i++)
			row_miss[i] = (5'(i) >= pos_q) || (row_q[i] == miss_q);
	end

	bncg_walker u_walk (
		.clk, .arst_n, .start,
		.parents(par_q[var_q]), .own_value(row_q[var_q]), .own_missing(row_miss[var_q]),
		.own_vc(vc_q[var_q]), .row_vals(row_q), .row_miss, .vcs(vc_q),
		.done, .status(wst), .cfg(wcfg), .jidx(wjidx)
	);

	assign qidx = {8'd0, req_q.query_config} * {10'd0, vc_q[req_q.target_variable]} +
		18'(req_q.query_value);
	assign q_ok = req_q.query_value < vc_q[req_q.target_variable] &&
		qidx < 18'(bncg_pkg::TABLE_DEPTH);

	always_comb begin
		jwe = 1'b0;
		jwa = {var_q, jidx_q};
		cwa = {var_q, cfg_q};
		jwd = bncg_pkg::sat_inc(jrd);
		cwd = bncg_pkg::sat_inc(crd);
		jra = {var_q, wjidx};
		cra = {var_q, wcfg};
		if (state_q == S_CLEAR) begin
			jwe = 1'b1;
			jwa = clr_q;
			cwa = clr_q;
			jwd = '0;
			cwd = '0;
		end else if (state_q == S_WB) begin
			jwe = 1'b1;
		end
		if (state_q == S_QRD || state_q == S_IDLE) begin
			jra = {req_q.target_variable, qidx[TW-1:0]};
			cra = {req_q.target_variable, req_q.query_config};
		end
	end

	bncg_ram #(.WIDTH(32), .DEPTH(bncg_pkg::MEM_DEPTH)) u_joint (
		.clk, .we(jwe), .waddr(jwa), .wdata(jwd), .raddr(jra), .rdata(jrd));
	bncg_ram #(.WIDTH(32), .DEPTH(bncg_pkg::MEM_DEPTH)) u_conf (
		.clk, .we(jwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd));

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign start = (state_q == S_WALK) && !out_valid;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			miss_q    <= 8'd255;
			pos_q     <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
			var_q     <= '0;
			req_q     <= '0;
			out_q     <= '0;
			cfg_q     <= '0;
			jidx_q    <= '0;
			for (int i = 0; i < VN; i++) begin
				row_q[i] <= 8'd255;
				par_q[i] <= '0;
				vc_q[i]  <= 8'd2;
				tot_q[i] <= '0;
			end
		end else begin
			if (cfg_we) miss_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						case (in_data.kind)
							bncg_pkg::KIND_ROW: begin
								if (pos_q < 5'(VN)) begin
									row_q[pos_q[3:0]] <= in_data.row_value;
									pos_q <= pos_q + 5'd1;
								end
								if (in_data.row_end) begin
									var_q   <= '0;
									state_q <= S_WALK;
								end
							end
							bncg_pkg::KIND_STRUCT: begin
								out_valid <= 1'b1;
								out_q <= '{variable: in_data.target_variable,
									status: (in_data.value_count == 8'd0) ?
										bncg_pkg::ST_RANGE : bncg_pkg::ST_COUNTED,
									config_index: '0, observed_value: in_data.value_count,
									joint_count: '0, config_count: '0,
									variable_total: '0, last: 1'b1};
								if (in_data.value_count != 8'd0) begin
									par_q[in_data.target_variable] <= in_data.parent_mask;
									vc_q[in_data.target_variable]  <= in_data.value_count;
								end
							end
							bncg_pkg::KIND_READ: state_q <= S_QRD;
							default: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(bncg_pkg::MEM_DEPTH - 1)) begin
						for (int i = 0; i < VN; i++) tot_q[i] <= '0;
						if (req_q.kind == bncg_pkg::KIND_CLEAR) begin
							out_valid <= 1'b1;
							out_q <= '{variable: '0, status: bncg_pkg::ST_COUNTED,
								config_index: '0, observed_value: '0, joint_count: '0,
								config_count: '0, variable_total: '0, last: 1'b1};
						end
						req_q.kind <= bncg_pkg::KIND_ROW;
						state_q <= S_IDLE;
					end
				end
				// The walk starts only once the previous result has been taken.
				S_WALK: if (!out_valid) state_q <= S_WAIT;
				S_WAIT: begin
					if (done) begin
						cfg_q  <= wcfg;
						jidx_q <= wjidx;
						out_q  <= '{variable: var_q, status: wst, config_index: '0,
							observed_value: row_q[var_q], joint_count: '0,
							config_count: '0, variable_total: '0,
							last: (var_q == 4'(VN - 1))};
						state_q <= (wst == bncg_pkg::ST_COUNTED) ? S_RD : S_OUT;
					end
				end
				S_RD: state_q <= S_WB;
				S_WB: begin
					tot_q[var_q] <= bncg_pkg::sat_inc(tot_q[var_q]);
					out_q.config_index   <= cfg_q;
					out_q.joint_count    <= bncg_pkg::sat_inc(jrd);
					out_q.config_count   <= bncg_pkg::sat_inc(crd);
					out_q.variable_total <= bncg_pkg::sat_inc(tot_q[var_q]);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						if (var_q == 4'(VN - 1)) begin
							pos_q <= '0;
							for (int i = 0; i < VN; i++) row_q[i] <= miss_q;
							state_q <= S_IDLE;
						end else begin
							var_q   <= var_q + 4'd1;
							state_q <= S_WALK;
						end
					end
				end
				S_QRD: state_q <= S_QOUT;
				S_QOUT: begin
					out_valid <= 1'b1;
					out_q <= '{variable: req_q.target_variable,
						status: q_ok ? bncg_pkg::ST_READ : bncg_pkg::ST_RANGE,
						config_index: req_q.query_config,
						observed_value: req_q.query_value,
						joint_count: q_ok ? jrd : 32'd0,
						config_count: q_ok ? crd : 32'd0,
						variable_total: q_ok ? tot_q[req_q.target_variable] : 32'd0,
						last: 1'b1};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
